@@ design/lfs_pkg.sv @@
// shared types, register codes and reset values for the line follower steering block
package lfs_pkg;

  localparam int unsigned SAMPLE_BITS_DEF  = 10;
  localparam int unsigned GAIN_DIVISOR_DEF = 200;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned STEPS_W    = 16;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned MODE_W     = 2;

  localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(300);
  localparam logic [STEPS_W-1:0] STEPS_RST       = STEPS_W'(1000);
  localparam logic [DUTY_W-1:0]  TURN_DUTY_RST   = DUTY_W'(204);
  localparam logic [DUTY_W-1:0]  INNER_DUTY_RST  = DUTY_W'(183);
  localparam logic [DUTY_W-1:0]  FULL_DUTY       = {DUTY_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_THRESHOLD   = 2'd0,
    REG_RECOVERY_STEPS   = 2'd1,
    REG_TURN_DUTY        = 2'd2,
    REG_PIVOT_INNER_DUTY = 2'd3
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ON_TRACK  = 2'd0,
    MODE_TRIM      = 2'd1,
    MODE_RECOVER   = 2'd2,
    MODE_OFF_TRACK = 2'd3
  } mode_e;

endpackage

@@ design/line_follow_steering_top.sv @@
// Line follower steering: one word of two sensor samples in, one word of motor and LED
// commands out. The block is a four-register pipeline (input register, decision and
// duty product, reciprocal multiply, quotient correction into the output register) and
// takes one word every clock while the output is not stalled; each result moves through
// the later registers in order. Steering state (recovery counter, last side, LEDs) is
// updated as a word leaves the input register, so back-to-back words see each other's
// state in order. The trimmed duty turn_duty*|m|/GAIN_DIVISOR is formed by a multiply by
// a fixed reciprocal and one correction step, which sets the pipeline depth. Configuration
// writes take effect at once and should only be issued while the pipeline is empty.
module line_follow_steering_top #(
  parameter int unsigned SAMPLE_BITS  = lfs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_DIVISOR = lfs_pkg::GAIN_DIVISOR_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [SAMPLE_BITS-1:0]           left_sample_i,
  input  logic [SAMPLE_BITS-1:0]           right_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             left_forward_o,
  output logic [lfs_pkg::DUTY_W-1:0]       left_duty_o,
  output logic                             right_forward_o,
  output logic [lfs_pkg::DUTY_W-1:0]       right_duty_o,
  output logic                             blue_led_o,
  output logic                             green_led_o,
  output logic [lfs_pkg::MODE_W-1:0]       mode_o
);
  import lfs_pkg::*;

  localparam int unsigned GW      = $clog2(GAIN_DIVISOR + 1);
  localparam int unsigned MAG_W   = (SAMPLE_BITS > GW) ? SAMPLE_BITS : GW;
  localparam int unsigned P_W     = DUTY_W + MAG_W;
  localparam int unsigned CMP_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int unsigned SAT_P   = 256 * GAIN_DIVISOR;
  localparam int unsigned CP_W    = $clog2(SAT_P + 1);
  localparam int unsigned RECIP_W = CP_W + 1;
  localparam int unsigned RP_W    = CP_W + RECIP_W;
  localparam int unsigned Q_W     = DUTY_W + 1;
  localparam int unsigned R_W     = CP_W + Q_W;
  localparam longint unsigned RECIP_L = (64'd1 << CP_W) / GAIN_DIVISOR;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [MAG_W-1:0]   GD_M  = MAG_W'(GAIN_DIVISOR);
  localparam logic [R_W-1:0]     GD_R  = R_W'(GAIN_DIVISOR);

  // configuration and steering state
  logic [THR_W-1:0]   thr_q;
  logic [STEPS_W-1:0] steps_q;
  logic [DUTY_W-1:0]  turn_q;
  logic [DUTY_W-1:0]  inner_q;
  logic               pivot_right_q, pivot_right_d;
  logic [STEPS_W-1:0] rec_cnt_q, rec_cnt_d;
  logic               blue_q, blue_d;
  logic               green_q, green_d;

  // pipeline registers
  logic                   s0_valid_q;
  logic [SAMPLE_BITS-1:0] s0_left_q, s0_right_q;

  logic              s1_valid_q, s1_trim_q, s1_blue_q, s1_green_q;
  mode_e             s1_mode_q;
  logic [1:0]        s1_fwd_q;
  logic [DUTY_W-1:0] s1_duty_q [2];
  logic [P_W-1:0]    s1_p_q    [2];

  logic              s2_valid_q, s2_trim_q, s2_blue_q, s2_green_q;
  mode_e             s2_mode_q;
  logic [1:0]        s2_fwd_q;
  logic [DUTY_W-1:0] s2_duty_q [2];
  logic [CP_W-1:0]   s2_pc_q   [2];
  logic [Q_W-1:0]    s2_qe_q   [2];

  logic              s3_valid_q, s3_blue_q, s3_green_q;
  mode_e             s3_mode_q;
  logic [1:0]        s3_fwd_q;
  logic [DUTY_W-1:0] s3_duty_q [2];

  logic en0, en1, en2, en3, step;

  assign en3        = !s3_valid_q || !out_stall_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign en0        = !s0_valid_q || en1;
  assign in_stall_o = !en0;
  assign step       = s0_valid_q && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      steps_q <= STEPS_RST;
      turn_q  <= TURN_DUTY_RST;
      inner_q <= INNER_DUTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_THRESHOLD:   thr_q   <= cfg_data_i[THR_W-1:0];
        REG_RECOVERY_STEPS:   steps_q <= cfg_data_i[STEPS_W-1:0];
        REG_TURN_DUTY:        turn_q  <= cfg_data_i[DUTY_W-1:0];
        REG_PIVOT_INNER_DUTY: inner_q <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en0) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      s0_left_q  <= left_sample_i;
      s0_right_q <= right_sample_i;
    end
  end

  // stage 1: steering decision, state update and duty product
  logic                   lo_l, lo_r, l_lt_r, inner_fwd;
  logic [SAMPLE_BITS-1:0] abs_d;
  logic [SAMPLE_BITS-1:0] ad [2];
  logic [MAG_W-1:0]       ad_m, mag;
  logic                   trim;
  mode_e                  mode_d;
  logic [1:0]             fwd_d;
  logic [DUTY_W-1:0]      duty_d [2];
  logic [P_W-1:0]         p_d    [2];

  always_comb begin
    lo_l      = CMP_W'(s0_left_q) < CMP_W'(thr_q);
    lo_r      = CMP_W'(s0_right_q) < CMP_W'(thr_q);
    l_lt_r    = s0_left_q < s0_right_q;
    abs_d     = l_lt_r ? (s0_right_q - s0_left_q) : (s0_left_q - s0_right_q);
    inner_fwd = inner_q != '0;

    pivot_right_d = pivot_right_q;
    rec_cnt_d     = rec_cnt_q;
    blue_d        = blue_q;
    green_d       = green_q;
    trim          = 1'b0;
    ad[0]         = '0;
    ad[1]         = '0;

    // pivot toward the side where the line was last seen
    if (pivot_right_q) begin
      fwd_d[0]  = inner_fwd;
      duty_d[0] = inner_q;
      fwd_d[1]  = 1'b0;
      duty_d[1] = turn_q;
    end else begin
      fwd_d[0]  = 1'b0;
      duty_d[0] = turn_q;
      fwd_d[1]  = inner_fwd;
      duty_d[1] = inner_q;
    end

    if (lo_l && lo_r) begin
      blue_d    = 1'b1;
      green_d   = 1'b0;
      rec_cnt_d = steps_q;
      mode_d    = MODE_OFF_TRACK;
    end else if (lo_l || lo_r) begin
      if (rec_cnt_q != '0) begin
        rec_cnt_d = rec_cnt_q - 1'b1;
        mode_d    = MODE_RECOVER;
      end else begin
        trim    = 1'b1;
        blue_d  = 1'b0;
        green_d = 1'b0;
        mode_d  = MODE_TRIM;
        if (l_lt_r) begin
          pivot_right_d = 1'b1;
          ad[1]         = abs_d;
        end else begin
          pivot_right_d = 1'b0;
          ad[0]         = abs_d;
        end
      end
    end else begin
      rec_cnt_d = '0;
      blue_d    = 1'b0;
      green_d   = 1'b1;
      fwd_d     = 2'b11;
      duty_d[0] = FULL_DUTY;
      duty_d[1] = FULL_DUTY;
      mode_d    = MODE_ON_TRACK;
    end

    // trimmed wheel: m = divisor - |l - r|, untrimmed wheel has m = divisor
    for (int i = 0; i < 2; i++) begin
      ad_m   = MAG_W'(ad[i]);
      mag    = (ad_m < GD_M) ? (GD_M - ad_m) : (ad_m - GD_M);
      p_d[i] = P_W'(turn_q) * P_W'(mag);
      if (trim) begin
        fwd_d[i] = (ad_m < GD_M) && (turn_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_right_q <= 1'b0;
      rec_cnt_q     <= '0;
      blue_q        <= 1'b0;
      green_q       <= 1'b0;
      s1_valid_q    <= 1'b0;
    end else begin
      if (step) begin
        pivot_right_q <= pivot_right_d;
        rec_cnt_q     <= rec_cnt_d;
        blue_q        <= blue_d;
        green_q       <= green_d;
      end
      if (en1) begin
        s1_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_trim_q  <= trim;
      s1_blue_q  <= blue_d;
      s1_green_q <= green_d;
      s1_mode_q  <= mode_d;
      s1_fwd_q   <= fwd_d;
      for (int i = 0; i < 2; i++) begin
        s1_duty_q[i] <= duty_d[i];
        s1_p_q[i]    <= p_d[i];
      end
    end
  end

  // stage 2: clip at 256 times the divisor, estimate quotient by reciprocal
  logic [CP_W-1:0] pc_d   [2];
  logic [RP_W-1:0] prod_d [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pc_d[i]   = (s1_p_q[i] >= P_W'(SAT_P)) ? CP_W'(SAT_P) : s1_p_q[i][CP_W-1:0];
      prod_d[i] = RP_W'(pc_d[i]) * RP_W'(RECIP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_trim_q  <= s1_trim_q;
      s2_blue_q  <= s1_blue_q;
      s2_green_q <= s1_green_q;
      s2_mode_q  <= s1_mode_q;
      s2_fwd_q   <= s1_fwd_q;
      for (int i = 0; i < 2; i++) begin
        s2_duty_q[i] <= s1_duty_q[i];
        s2_pc_q[i]   <= pc_d[i];
        s2_qe_q[i]   <= prod_d[i][CP_W +: Q_W];
      end
    end
  end

  // stage 3: estimate is exact or one low, then saturate
  logic [R_W-1:0]    rem_d  [2];
  logic [Q_W:0]      q_d    [2];
  logic [DUTY_W-1:0] tdut_d [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_d[i]  = R_W'(s2_pc_q[i]) - (R_W'(s2_qe_q[i]) * GD_R);
      q_d[i]    = (Q_W + 1)'(s2_qe_q[i]) + (Q_W + 1)'(rem_d[i] >= GD_R);
      tdut_d[i] = (q_d[i] > (Q_W + 1)'(FULL_DUTY)) ? FULL_DUTY : q_d[i][DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_q) begin
      s3_blue_q  <= s2_blue_q;
      s3_green_q <= s2_green_q;
      s3_mode_q  <= s2_mode_q;
      s3_fwd_q   <= s2_fwd_q;
      for (int i = 0; i < 2; i++) begin
        s3_duty_q[i] <= s2_trim_q ? tdut_d[i] : s2_duty_q[i];
      end
    end
  end

  assign out_valid_o     = s3_valid_q;
  assign left_forward_o  = s3_fwd_q[0];
  assign left_duty_o     = s3_duty_q[0];
  assign right_forward_o = s3_fwd_q[1];
  assign right_duty_o    = s3_duty_q[1];
  assign blue_led_o      = s3_blue_q;
  assign green_led_o     = s3_green_q;
  assign mode_o          = s3_mode_q;

endmodule

@@ design/lfs_checker.sv @@
// port-level checks for the line follower steering block, bound to the top level
module lfs_checker #(
  parameter int unsigned SAMPLE_BITS  = lfs_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned GAIN_DIVISOR = lfs_pkg::GAIN_DIVISOR_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [SAMPLE_BITS-1:0]         left_sample_i,
  input logic [SAMPLE_BITS-1:0]         right_sample_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           left_forward_o,
  input logic [lfs_pkg::DUTY_W-1:0]     left_duty_o,
  input logic                           right_forward_o,
  input logic [lfs_pkg::DUTY_W-1:0]     right_duty_o,
  input logic                           blue_led_o,
  input logic                           green_led_o,
  input logic [lfs_pkg::MODE_W-1:0]     mode_o
);
  import lfs_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_duty_o)
      && $stable(right_duty_o) && $stable(mode_o) && $stable(left_forward_o)
      && $stable(right_forward_o))
    else $error("stalled result word changed");

  // on track drives both wheels forward at full duty with the green led
  a_on_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == MODE_ON_TRACK) |-> left_forward_o && right_forward_o
      && (left_duty_o == FULL_DUTY) && (right_duty_o == FULL_DUTY)
      && green_led_o && !blue_led_o)
    else $error("on-track word is not full forward");

  // off track pivots with the outer wheel reversed and the blue led lit
  a_off_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == MODE_OFF_TRACK) |-> blue_led_o && !green_led_o
      && !(left_forward_o && right_forward_o))
    else $error("off-track word is not a pivot");

  // trim steering turns both leds off
  a_trim_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == MODE_TRIM) |-> !blue_led_o && !green_led_o)
    else $error("led lit during trim steering");

endmodule

bind line_follow_steering_top lfs_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .GAIN_DIVISOR(GAIN_DIVISOR)
) u_lfs_checker (.*);

@@ tb/sv/lfs_tb_pkg.sv @@
// steering predictor and result scoreboard for the line follower testbench
`timescale 1ns / 100ps
package lfs_tb_pkg;
  import lfs_pkg::*;

  localparam int SB_W = SAMPLE_BITS_DEF;
  localparam int GAIN = GAIN_DIVISOR_DEF;

  typedef struct packed {
    logic              left_fwd;
    logic [DUTY_W-1:0] left_duty;
    logic              right_fwd;
    logic [DUTY_W-1:0] right_duty;
    logic              blue;
    logic              green;
    mode_e             mode;
  } motor_cmd_t;

  class steering_scoreboard;
    logic [THR_W-1:0]   threshold;
    logic [STEPS_W-1:0] reload;
    logic [DUTY_W-1:0]  turn;
    logic [DUTY_W-1:0]  inner;
    logic               pivot_right;
    logic [STEPS_W-1:0] countdown;
    logic               blue;
    logic               green;
    motor_cmd_t         cmd_q[$];
    int unsigned        errors;

    function new();
      threshold   = THRESHOLD_RST;
      reload      = STEPS_RST;
      turn        = TURN_DUTY_RST;
      inner       = INNER_DUTY_RST;
      pivot_right = 1'b0;
      countdown   = '0;
      blue        = 1'b0;
      green       = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LINE_THRESHOLD:   threshold = data[THR_W-1:0];
        REG_RECOVERY_STEPS:   reload    = data[STEPS_W-1:0];
        REG_TURN_DUTY:        turn      = data[DUTY_W-1:0];
        REG_PIVOT_INNER_DUTY: inner     = data[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction

    // direction and duty of one trimmed wheel, m in units of 1/GAIN
    function logic [DUTY_W:0] wheel_cmd(int m);
      int mag;
      int d;
      mag = (m < 0) ? -m : m;
      d = int'(turn) * mag / GAIN;
      if (d > 255) d = 255;
      return {(m > 0 && turn != 0), d[DUTY_W-1:0]};
    endfunction

    function void pivot_cmd(ref motor_cmd_t c);
      if (pivot_right) begin
        c.left_fwd  = (inner != 0);
        c.left_duty = inner;
        c.right_fwd = 1'b0;
        c.right_duty = turn;
      end else begin
        c.left_fwd  = 1'b0;
        c.left_duty = turn;
        c.right_fwd = (inner != 0);
        c.right_duty = inner;
      end
    endfunction

    function void note_input(logic [SB_W-1:0] l, logic [SB_W-1:0] r);
      motor_cmd_t c;
      logic lo_l;
      logic lo_r;
      int diff;
      int ml;
      int mr;
      c = '0;
      lo_l = l < threshold;
      lo_r = r < threshold;
      if (lo_l && lo_r) begin
        blue = 1'b1;
        green = 1'b0;
        countdown = reload;
        pivot_cmd(c);
        c.mode = MODE_OFF_TRACK;
      end else if (lo_l || lo_r) begin
        if (countdown != 0) begin
          pivot_cmd(c);
          countdown = countdown - 1'b1;
          c.mode = MODE_RECOVER;
        end else begin
          diff = int'(l) - int'(r);
          ml = GAIN;
          mr = GAIN;
          blue = 1'b0;
          green = 1'b0;
          // equal samples fall on the left side
          if (diff < 0) begin
            pivot_right = 1'b1;
            mr = GAIN + diff;
          end else begin
            pivot_right = 1'b0;
            ml = GAIN - diff;
          end
          {c.left_fwd, c.left_duty} = wheel_cmd(ml);
          {c.right_fwd, c.right_duty} = wheel_cmd(mr);
          c.mode = MODE_TRIM;
        end
      end else begin
        countdown = '0;
        blue = 1'b0;
        green = 1'b1;
        c.left_fwd = 1'b1;
        c.left_duty = FULL_DUTY;
        c.right_fwd = 1'b1;
        c.right_duty = FULL_DUTY;
        c.mode = MODE_ON_TRACK;
      end
      c.blue = blue;
      c.green = green;
      cmd_q.push_back(c);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(motor_cmd_t got);
      motor_cmd_t want;
      if (cmd_q.size() == 0) begin
        report($sformatf("word with nothing outstanding, mode %0d", got.mode));
      end else begin
        want = cmd_q.pop_front();
        check_field("left_forward", got.left_fwd, want.left_fwd);
        check_field("left_duty", got.left_duty, want.left_duty);
        check_field("right_forward", got.right_fwd, want.right_fwd);
        check_field("right_duty", got.right_duty, want.right_duty);
        check_field("blue_led", got.blue, want.blue);
        check_field("green_led", got.green, want.green);
        check_field("mode", got.mode, want.mode);
      end
    endtask
  endclass

endpackage

@@ tb/sv/line_follow_steering_top_tb.sv @@
// testbench top for the line follower steering block
`timescale 1ns / 100ps
module line_follow_steering_top_tb;
  import lfs_pkg::*;
  import lfs_tb_pkg::*;

  localparam int LATENCY = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int SMAX = (1 << SB_W) - 1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [SB_W-1:0]       left_sample_i = '0;
  logic [SB_W-1:0]       right_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  left_forward_o;
  logic [DUTY_W-1:0]     left_duty_o;
  logic                  right_forward_o;
  logic [DUTY_W-1:0]     right_duty_o;
  logic                  blue_led_o;
  logic                  green_led_o;
  logic [MODE_W-1:0]     mode_o;

  steering_scoreboard sb;
  motor_cmd_t         seen;
  logic               steady = 1'b0;
  int unsigned        quiet_cycles = 0;

  line_follow_steering_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_forward_o (left_forward_o),
    .left_duty_o    (left_duty_o),
    .right_forward_o(right_forward_o),
    .right_duty_o   (right_duty_o),
    .blue_led_o     (blue_led_o),
    .green_led_o    (green_led_o),
    .mode_o         (mode_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 28);
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.left_fwd   = left_forward_o;
        seen.left_duty  = left_duty_o;
        seen.right_fwd  = right_forward_o;
        seen.right_duty = right_duty_o;
        seen.blue       = blue_led_o;
        seen.green      = green_led_o;
        seen.mode       = mode_e'(mode_o);
        sb.check_result(seen);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_word(logic [SB_W-1:0] l, logic [SB_W-1:0] r);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_sample_i <= l;
    right_sample_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(l, r);
  endtask

  // hold off until every word is back and the pipeline has emptied
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] steps,
                           logic [CFG_DATA_W-1:0] turn, logic [CFG_DATA_W-1:0] inner);
    settle();
    set_reg(REG_LINE_THRESHOLD, thr);
    set_reg(REG_RECOVERY_STEPS, steps);
    set_reg(REG_TURN_DUTY, turn);
    set_reg(REG_PIVOT_INNER_DUTY, inner);
  endtask

  function automatic logic [SB_W-1:0] low_sample();
    if (sb.threshold == 0) return '0;
    if ($urandom_range(7) == 0) return sb.threshold - 1'b1;
    return SB_W'($urandom_range(int'(sb.threshold) - 1, 0));
  endfunction

  function automatic logic [SB_W-1:0] high_sample();
    if ($urandom_range(7) == 0) return sb.threshold;
    return SB_W'($urandom_range(SMAX, int'(sb.threshold)));
  endfunction

  task automatic random_word();
    logic [SB_W-1:0] l;
    logic [SB_W-1:0] r;
    case ($urandom_range(9))
      0, 1, 2: begin
        l = high_sample();
        r = high_sample();
      end
      3, 4: begin
        l = low_sample();
        r = low_sample();
      end
      5, 6, 7, 8: begin
        if ($urandom_range(1)) begin
          l = low_sample();
          r = high_sample();
        end else begin
          l = high_sample();
          r = low_sample();
        end
      end
      default: begin
        l = SB_W'($urandom);
        r = SB_W'($urandom);
      end
    endcase
    send_word(l, r);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: track, trim both ways, threshold edges, loss and recovery
    send_word(SMAX, SMAX);
    send_word(0, SMAX);
    send_word(SMAX, 0);
    send_word(299, 300);
    send_word(300, 299);
    send_word(0, 0);
    send_word(0, 500);
    send_word(SMAX, SMAX);
    send_word(100, 400);

    // zero reload, zero duties, junk above the threshold field
    configure(16'hFC00 | 16'd300, 16'd0, 16'd0, 16'd0);
    send_word(0, 0);
    send_word(0, 600);
    send_word(600, 0);
    send_word(700, 700);

    configure(16'd1023, 16'd3, 16'd255, 16'd255);
    send_word(SMAX - 1, SMAX - 1);
    repeat (3) send_word(SMAX, 5);
    send_word(SMAX, 5);
    send_word(5, SMAX);
    send_word(SMAX, SMAX);

    configure(16'd0, 16'd1000, 16'd204, 16'd183);
    send_word(0, 0);
    send_word(SMAX, 0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: configure(16'd1, 16'd0, 16'd0, 16'd0);
        default: configure(16'($urandom) | 16'($urandom_range(SMAX)),
                           16'($urandom_range(12)),
                           16'($urandom),
                           16'($urandom));
      endcase
      steady = (p == 2);
      for (int k = 0; k < 92; k++) begin
        if (p == 3 && k == 46) settle();
        random_word();
      end
    end
    steady = 1'b0;
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ line_follow_steering_top.f @@
design/lfs_pkg.sv
design/line_follow_steering_top.sv
design/lfs_checker.sv
tb/sv/lfs_tb_pkg.sv
tb/sv/line_follow_steering_top_tb.sv
